/* rtl/core/tcw_pkg.sv */
`default_nettype none

package tcw_pkg;

    // Command codes on the input channel
    typedef enum logic [3:0] {
        OP_SET     = 4'd0,
        OP_HOME    = 4'd1,
        OP_LEFT    = 4'd2,
        OP_RIGHT   = 4'd3,
        OP_DOWN    = 4'd4,
        OP_UP      = 4'd5,
        OP_RETURN  = 4'd6,
        OP_WRITE   = 4'd7,
        OP_SHOW    = 4'd8,
        OP_HIDE    = 4'd9,
        OP_ENABLE  = 4'd10,
        OP_DISABLE = 4'd11
    } t_op;

    typedef enum logic [1:0] {
        SCROLL_NONE = 2'd0,
        SCROLL_UP   = 2'd1,
        SCROLL_DOWN = 2'd2
    } t_scroll;

    // Register index, byte address bits [3:2]
    typedef enum logic [1:0] {
        REG_WIN_LEFT   = 2'd0,
        REG_WIN_RIGHT  = 2'd1,
        REG_WIN_TOP    = 2'd2,
        REG_WIN_BOTTOM = 2'd3
    } t_reg;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int CODE_W  = 8;

    localparam logic [CODE_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CODE_W-1:0] CHAR_DEL   = 8'd127;

    localparam int WIN_RIGHT_RST  = 79;
    localparam int WIN_BOTTOM_RST = 59;

    // Side effects of one command
    typedef struct packed {
        t_scroll scroll;
        logic    draw;
        logic    invert;
    } t_flags;

endpackage

`default_nettype wire

/* rtl/core/tcw_cfg.sv */
`default_nettype none

module tcw_cfg #(
    parameter int COL_BITS = 7,
    parameter int ROW_BITS = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tcw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tcw_pkg::DATA_W-1:0] pwdata,
    output logic      [tcw_pkg::DATA_W-1:0] prdata,
    output logic      [COL_BITS-1:0]        o_win_left,
    output logic      [COL_BITS-1:0]        o_win_right,
    output logic      [ROW_BITS-1:0]        o_win_top,
    output logic      [ROW_BITS-1:0]        o_win_bottom
);
    import tcw_pkg::*;

    logic [COL_BITS-1:0] r_win_left;
    logic [COL_BITS-1:0] r_win_right;
    logic [ROW_BITS-1:0] r_win_top;
    logic [ROW_BITS-1:0] r_win_bottom;
    logic                w_wr;
    t_reg                w_idx;

    assign w_wr  = psel && penable && pwrite;
    assign w_idx = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_right  <= COL_BITS'(WIN_RIGHT_RST);
            r_win_top    <= '0;
            r_win_bottom <= ROW_BITS'(WIN_BOTTOM_RST);
        end else if (w_wr) begin
            case (w_idx)
                REG_WIN_LEFT:   r_win_left   <= pwdata[COL_BITS-1:0];
                REG_WIN_RIGHT:  r_win_right  <= pwdata[COL_BITS-1:0];
                REG_WIN_TOP:    r_win_top    <= pwdata[ROW_BITS-1:0];
                REG_WIN_BOTTOM: r_win_bottom <= pwdata[ROW_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_WIN_LEFT:   prdata = DATA_W'(r_win_left);
            REG_WIN_RIGHT:  prdata = DATA_W'(r_win_right);
            REG_WIN_TOP:    prdata = DATA_W'(r_win_top);
            REG_WIN_BOTTOM: prdata = DATA_W'(r_win_bottom);
            default:        prdata = '0;
        endcase
    end

    assign o_win_left   = r_win_left;
    assign o_win_right  = r_win_right;
    assign o_win_top    = r_win_top;
    assign o_win_bottom = r_win_bottom;

endmodule

`default_nettype wire

/* rtl/core/tcw_core.sv */
`default_nettype none

module tcw_core #(
    parameter int COL_BITS = 7,
    parameter int ROW_BITS = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [3:0]                 i_op,
    input  wire logic [tcw_pkg::CODE_W-1:0] i_code,
    input  wire logic [COL_BITS-1:0]        i_set_col,
    input  wire logic [ROW_BITS-1:0]        i_set_row,
    input  wire logic [COL_BITS-1:0]        i_win_left,
    input  wire logic [COL_BITS-1:0]        i_win_right,
    input  wire logic [ROW_BITS-1:0]        i_win_top,
    input  wire logic [ROW_BITS-1:0]        i_win_bottom,
    output logic      [COL_BITS-1:0]        o_col,
    output logic      [ROW_BITS-1:0]        o_row,
    output tcw_pkg::t_flags                 o_flags,
    output logic      [COL_BITS-1:0]        o_draw_col,
    output logic      [ROW_BITS-1:0]        o_draw_row,
    output logic      [tcw_pkg::CODE_W-1:0] o_draw_code
);
    import tcw_pkg::*;

    logic [COL_BITS-1:0] r_cur_col, n_cur_col;
    logic [ROW_BITS-1:0] r_cur_row, n_cur_row;
    logic                r_shown, n_shown;
    logic                r_allowed, n_allowed;

    logic [COL_BITS-1:0] w_col_span;
    logic [ROW_BITS-1:0] w_row_span;
    logic [COL_BITS:0]   w_col_inc;
    logic [ROW_BITS:0]   w_row_inc;
    logic                w_col_end;
    logic                w_row_end;
    logic [COL_BITS:0]   w_abs_col;
    logic [ROW_BITS:0]   w_abs_row;
    logic                w_printable;
    logic                w_inside;
    logic                w_do_draw;
    t_op                 w_op;

    // Span collapses to one cell on an inverted axis
    assign w_col_span = (i_win_right >= i_win_left) ? (i_win_right - i_win_left) : '0;
    assign w_row_span = (i_win_bottom >= i_win_top) ? (i_win_bottom - i_win_top) : '0;

    assign w_col_inc = {1'b0, r_cur_col} + (COL_BITS+1)'(1);
    assign w_row_inc = {1'b0, r_cur_row} + (ROW_BITS+1)'(1);
    assign w_col_end = w_col_inc > {1'b0, w_col_span};
    assign w_row_end = w_row_inc > {1'b0, w_row_span};

    assign w_abs_col   = {1'b0, r_cur_col} + {1'b0, i_win_left};
    assign w_abs_row   = {1'b0, r_cur_row} + {1'b0, i_win_top};
    assign w_inside    = (w_abs_col <= {1'b0, i_win_right}) &&
                         (w_abs_row <= {1'b0, i_win_bottom});
    assign w_printable = (i_code >= CHAR_SPACE) && (i_code != CHAR_DEL);
    assign w_op        = t_op'(i_op);
    assign w_do_draw   = (w_op == OP_WRITE) && w_printable && w_inside;

    always_comb begin
        n_cur_col      = r_cur_col;
        n_cur_row      = r_cur_row;
        n_shown        = r_shown;
        n_allowed      = r_allowed;
        o_flags.scroll = SCROLL_NONE;
        o_flags.draw   = 1'b0;
        o_flags.invert = 1'b0;
        case (w_op)
            OP_SET: begin
                if (i_set_col <= w_col_span && i_set_row <= w_row_span) begin
                    n_cur_col = i_set_col;
                    n_cur_row = i_set_row;
                end
            end
            OP_HOME: begin
                n_cur_col = '0;
                n_cur_row = '0;
            end
            OP_LEFT: begin
                if (r_cur_col == '0) begin
                    n_cur_col = w_col_span;
                    if (r_cur_row == '0) begin
                        o_flags.scroll = SCROLL_DOWN;
                    end else begin
                        n_cur_row = r_cur_row - ROW_BITS'(1);
                    end
                end else begin
                    n_cur_col = r_cur_col - COL_BITS'(1);
                end
            end
            OP_RIGHT, OP_WRITE: begin
                o_flags.draw = w_do_draw;
                if (w_col_end) begin
                    n_cur_col = '0;
                    if (w_row_end) begin
                        o_flags.scroll = SCROLL_UP;
                    end else begin
                        n_cur_row = w_row_inc[ROW_BITS-1:0];
                    end
                end else begin
                    n_cur_col = w_col_inc[COL_BITS-1:0];
                end
            end
            OP_DOWN: begin
                if (w_row_end) begin
                    o_flags.scroll = SCROLL_UP;
                end else begin
                    n_cur_row = w_row_inc[ROW_BITS-1:0];
                end
            end
            OP_UP: begin
                if (r_cur_row == '0) begin
                    o_flags.scroll = SCROLL_DOWN;
                end else begin
                    n_cur_row = r_cur_row - ROW_BITS'(1);
                end
            end
            OP_RETURN: begin
                n_cur_col = '0;
            end
            OP_SHOW: begin
                if (!r_shown && r_allowed) begin
                    o_flags.invert = 1'b1;
                    n_shown        = 1'b1;
                end
            end
            OP_HIDE: begin
                if (r_shown) begin
                    o_flags.invert = 1'b1;
                    n_shown        = 1'b0;
                end
            end
            OP_ENABLE: begin
                n_allowed = 1'b1;
            end
            OP_DISABLE: begin
                if (r_shown) begin
                    o_flags.invert = 1'b1;
                    n_shown        = 1'b0;
                end
                n_allowed = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_shown   <= 1'b0;
            r_allowed <= 1'b1;
        end else if (i_step) begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_shown   <= n_shown;
            r_allowed <= n_allowed;
        end
    end

    assign o_col       = n_cur_col;
    assign o_row       = n_cur_row;
    assign o_draw_col  = w_do_draw ? w_abs_col[COL_BITS-1:0] : '0;
    assign o_draw_row  = w_do_draw ? w_abs_row[ROW_BITS-1:0] : '0;
    assign o_draw_code = w_do_draw ? i_code : '0;

endmodule

`default_nettype wire

/* rtl/core/text_cursor_window_controller_top.sv */
// Text cursor window controller.
// Input channel (i_valid/o_ready) carries one command per transfer: operation,
// char_code and the window-relative set_col/set_row used by the set command.
// Output channel (o_valid/i_ready) returns exactly one result per command:
// the cursor position after the command, a scroll request, an optional draw
// request at an absolute cell and an invert-cell flag for cursor show/hide.
// Window bounds sit in four APB registers at byte addresses 0, 4, 8 and 12
// (left, right, top, bottom); writes complete in the access cycle, pready is
// tied high. Write them only while no command is in flight.
// A transferred command is captured in the command register, executed
// against the cursor state once the result register is free or being
// drained, and its result is loaded into the result register, which
// drives o_valid; the result transfers when i_ready is high.
// Throughput: one command per cycle; the command register and the result
// register are both live, so a new command is taken while a result waits.
// When the receiver stalls, the result holds and the command register fills;
// o_ready then drops until the result is taken.
// Reset (synchronous, active low): window 0..79 x 0..59, cursor at (0,0),
// cursor hidden and enabled, both pipeline registers empty.
`default_nettype none

module text_cursor_window_controller_top #(
    parameter int COL_BITS = 7,
    parameter int ROW_BITS = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // command channel
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [3:0]                 i_operation,
    input  wire logic [tcw_pkg::CODE_W-1:0] i_char_code,
    input  wire logic [COL_BITS-1:0]        i_set_col,
    input  wire logic [ROW_BITS-1:0]        i_set_row,
    // result channel
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [COL_BITS-1:0]        o_cursor_col,
    output logic      [ROW_BITS-1:0]        o_cursor_row,
    output logic      [1:0]                 o_scroll_req,
    output logic                            o_draw_valid,
    output logic      [COL_BITS-1:0]        o_draw_col,
    output logic      [ROW_BITS-1:0]        o_draw_row,
    output logic      [tcw_pkg::CODE_W-1:0] o_draw_code,
    output logic                            o_invert_cell,
    // register port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tcw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tcw_pkg::DATA_W-1:0] pwdata,
    output logic      [tcw_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import tcw_pkg::*;

    // command register
    logic                r_in_valid;
    logic [3:0]          r_op;
    logic [CODE_W-1:0]   r_code;
    logic [COL_BITS-1:0] r_set_col;
    logic [ROW_BITS-1:0] r_set_row;

    // result register
    logic                r_out_valid;
    logic [COL_BITS-1:0] r_col;
    logic [ROW_BITS-1:0] r_row;
    t_flags              r_flags;
    logic [COL_BITS-1:0] r_draw_col;
    logic [ROW_BITS-1:0] r_draw_row;
    logic [CODE_W-1:0]   r_draw_code;

    logic [COL_BITS-1:0] w_win_left;
    logic [COL_BITS-1:0] w_win_right;
    logic [ROW_BITS-1:0] w_win_top;
    logic [ROW_BITS-1:0] w_win_bottom;

    logic [COL_BITS-1:0] w_col;
    logic [ROW_BITS-1:0] w_row;
    t_flags              w_flags;
    logic [COL_BITS-1:0] w_draw_col;
    logic [ROW_BITS-1:0] w_draw_row;
    logic [CODE_W-1:0]   w_draw_code;

    logic                w_adv;

    // Command executes when the result register is free or being drained
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;
    assign pready  = 1'b1;

    tcw_cfg #(
        .COL_BITS (COL_BITS),
        .ROW_BITS (ROW_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .o_win_left   (w_win_left),
        .o_win_right  (w_win_right),
        .o_win_top    (w_win_top),
        .o_win_bottom (w_win_bottom)
    );

    tcw_core #(
        .COL_BITS (COL_BITS),
        .ROW_BITS (ROW_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_op         (r_op),
        .i_code       (r_code),
        .i_set_col    (r_set_col),
        .i_set_row    (r_set_row),
        .i_win_left   (w_win_left),
        .i_win_right  (w_win_right),
        .i_win_top    (w_win_top),
        .i_win_bottom (w_win_bottom),
        .o_col        (w_col),
        .o_row        (w_row),
        .o_flags      (w_flags),
        .o_draw_col   (w_draw_col),
        .o_draw_row   (w_draw_row),
        .o_draw_code  (w_draw_code)
    );

    // Command register: loads whenever there is room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_op      <= i_operation;
            r_code    <= i_char_code;
            r_set_col <= i_set_col;
            r_set_row <= i_set_row;
        end
    end

    // Result register: holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_col       <= w_col;
            r_row       <= w_row;
            r_flags     <= w_flags;
            r_draw_col  <= w_draw_col;
            r_draw_row  <= w_draw_row;
            r_draw_code <= w_draw_code;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_cursor_col  = r_col;
    assign o_cursor_row  = r_row;
    assign o_scroll_req  = r_flags.scroll;
    assign o_draw_valid  = r_flags.draw;
    assign o_draw_col    = r_draw_col;
    assign o_draw_row    = r_draw_row;
    assign o_draw_code   = r_draw_code;
    assign o_invert_cell = r_flags.invert;

`ifndef SYNTH
    // Drawn codes are always printable
    a_draw_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_draw_valid) |-> (o_draw_code >= CHAR_SPACE && o_draw_code != CHAR_DEL))
        else $error("draw request with non-printable code");

    // Draw fields are cleared when there is no draw
    a_draw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_draw_valid) |->
            (o_draw_col == '0 && o_draw_row == '0 && o_draw_code == '0))
        else $error("draw fields not cleared");

    // A write never inverts and a show/hide never draws
    a_draw_xor_invert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_draw_valid && o_invert_cell))
        else $error("draw and invert in one result");

    // Full pipeline under a stalled receiver must stop the command side
    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("command taken while both registers are full");

    // A stalled result does not move
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_col) && $stable(r_row)))
        else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

/* sim/text_cursor_window_controller_top_tb.sv */
`timescale 1ns / 100ps

module text_cursor_window_controller_top_tb;
    import tcw_pkg::*;

    localparam int COL_BITS    = 7;
    localparam int ROW_BITS    = 6;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills both pipeline regs
    localparam int SETTLE      = 4;     // two register stages from transfer to o_valid

    // opcodes with no named meaning, the block must treat them as no-ops
    localparam logic [3:0] OP_SPARE_LO = 4'd12;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [3:0]          op;
        logic [CODE_W-1:0]   code;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
    } t_cursor_cmd;

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic [1:0]          scroll;
        logic                draw;
        logic [COL_BITS-1:0] draw_col;
        logic [ROW_BITS-1:0] draw_row;
        logic [CODE_W-1:0]   draw_code;
        logic                invert;
    } t_cursor_result;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    wire logic           o_ready;
    logic [3:0]          i_operation = '0;
    logic [CODE_W-1:0]   i_char_code = '0;
    logic [COL_BITS-1:0] i_set_col   = '0;
    logic [ROW_BITS-1:0] i_set_row   = '0;
    wire logic           o_valid;
    logic                i_ready     = 1'b0;
    wire logic [COL_BITS-1:0] o_cursor_col;
    wire logic [ROW_BITS-1:0] o_cursor_row;
    wire logic [1:0]          o_scroll_req;
    wire logic                o_draw_valid;
    wire logic [COL_BITS-1:0] o_draw_col;
    wire logic [ROW_BITS-1:0] o_draw_row;
    wire logic [CODE_W-1:0]   o_draw_code;
    wire logic                o_invert_cell;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    wire logic [DATA_W-1:0] prdata;
    wire logic           pready;

    text_cursor_window_controller_top #(
        .COL_BITS(COL_BITS),
        .ROW_BITS(ROW_BITS)
    ) uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cursor predictor: own copy of the window registers and cursor state
    // ------------------------------------------------------------------
    int wnd_left   = 0;
    int wnd_right  = WIN_RIGHT_RST;
    int wnd_top    = 0;
    int wnd_bottom = WIN_BOTTOM_RST;
    int pos_col    = 0;
    int pos_row    = 0;
    bit caret_visible = 1'b0;
    bit caret_enabled = 1'b1;

    // inverted axis collapses to a single cell
    function automatic int col_span();
        return (wnd_right >= wnd_left) ? wnd_right - wnd_left : 0;
    endfunction

    function automatic int row_span();
        return (wnd_bottom >= wnd_top) ? wnd_bottom - wnd_top : 0;
    endfunction

    // at or past the last row: stay put, ask for the content to move up
    function automatic logic [1:0] step_down();
        if (pos_row + 1 > row_span()) begin
            return SCROLL_UP;
        end
        pos_row++;
        return SCROLL_NONE;
    endfunction

    function automatic logic [1:0] step_up();
        if (pos_row == 0) begin
            return SCROLL_DOWN;
        end
        pos_row--;
        return SCROLL_NONE;
    endfunction

    function automatic logic [1:0] step_right();
        if (pos_col + 1 > col_span()) begin
            pos_col = 0;
            return step_down();
        end
        pos_col++;
        return SCROLL_NONE;
    endfunction

    function automatic t_cursor_result cursor_step(t_cursor_cmd c);
        t_cursor_result r;
        int abs_col;
        int abs_row;
        r = '0;
        case (c.op)
            OP_SET: begin
                // a target outside the window is dropped
                if (int'(c.col) <= col_span() && int'(c.row) <= row_span()) begin
                    pos_col = int'(c.col);
                    pos_row = int'(c.row);
                end
            end
            OP_HOME: begin
                pos_col = 0;
                pos_row = 0;
            end
            OP_LEFT: begin
                if (pos_col == 0) begin
                    pos_col = col_span();
                    r.scroll = step_up();
                end else begin
                    pos_col--;
                end
            end
            OP_RIGHT:  r.scroll = step_right();
            OP_DOWN:   r.scroll = step_down();
            OP_UP:     r.scroll = step_up();
            OP_RETURN: pos_col = 0;
            OP_WRITE: begin
                abs_col = pos_col + wnd_left;
                abs_row = pos_row + wnd_top;
                // control codes and DEL advance without drawing, as does a cell
                // outside the window (cursor left beyond a shrunk window)
                if (c.code >= CHAR_SPACE && c.code != CHAR_DEL &&
                    abs_col <= wnd_right && abs_row <= wnd_bottom) begin
                    r.draw      = 1'b1;
                    r.draw_col  = COL_BITS'(abs_col);
                    r.draw_row  = ROW_BITS'(abs_row);
                    r.draw_code = c.code;
                end
                r.scroll = step_right();
            end
            OP_SHOW: begin
                if (!caret_visible && caret_enabled) begin
                    r.invert      = 1'b1;
                    caret_visible = 1'b1;
                end
            end
            OP_HIDE: begin
                if (caret_visible) begin
                    r.invert      = 1'b1;
                    caret_visible = 1'b0;
                end
            end
            OP_ENABLE: caret_enabled = 1'b1;
            OP_DISABLE: begin
                if (caret_visible) begin
                    r.invert      = 1'b1;
                    caret_visible = 1'b0;
                end
                caret_enabled = 1'b0;
            end
            default: ;
        endcase
        r.col = COL_BITS'(pos_col);
        r.row = ROW_BITS'(pos_row);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    t_cursor_cmd    command_queue[$];
    t_cursor_result expected_results[$];
    int             cmds_queued   = 0;
    int             cmds_accepted = 0;
    int             mismatch_count = 0;
    int             cycle_count   = 0;
    bit             gaps_on       = 1'b0;   // random idling on both channels
    int             hold_seq      = 0;      // bump to request a long receiver hold-off

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Command driver: one transfer per valid&ready edge, prediction taken
    // at the transfer so it sees the command stream in order
    // ------------------------------------------------------------------
    t_cursor_cmd tx_cmd;
    int          tx_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(cursor_step(tx_cmd));
                cmds_accepted++;
            end
            // slot is free when nothing is offered or the offer just went through
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (command_queue.size() > 0) begin
                    tx_cmd = command_queue.pop_front();
                    i_valid     <= 1'b1;
                    i_operation <= tx_cmd.op;
                    i_char_code <= tx_cmd.code;
                    i_set_col   <= tx_cmd.col;
                    i_set_row   <= tx_cmd.row;
                    tx_gap = gaps_on ? idle_len() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (gaps_on) begin
            n = idle_len();
            stall_left = (n > 0) ? n - 1 : 0;
            i_ready <= (n == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every transfer against the oldest prediction
    // ------------------------------------------------------------------
    t_cursor_result rx_want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no command pending", 1, 0);
            end else begin
                rx_want = expected_results.pop_front();
                if (o_cursor_col !== rx_want.col)
                    report_mismatch("cursor_col", o_cursor_col, rx_want.col);
                if (o_cursor_row !== rx_want.row)
                    report_mismatch("cursor_row", o_cursor_row, rx_want.row);
                if (o_scroll_req !== rx_want.scroll)
                    report_mismatch("scroll_req", o_scroll_req, rx_want.scroll);
                if (o_draw_valid !== rx_want.draw)
                    report_mismatch("draw_valid", o_draw_valid, rx_want.draw);
                if (o_draw_col !== rx_want.draw_col)
                    report_mismatch("draw_col", o_draw_col, rx_want.draw_col);
                if (o_draw_row !== rx_want.draw_row)
                    report_mismatch("draw_row", o_draw_row, rx_want.draw_row);
                if (o_draw_code !== rx_want.draw_code)
                    report_mismatch("draw_code", o_draw_code, rx_want.draw_code);
                if (o_invert_cell !== rx_want.invert)
                    report_mismatch("invert_cell", o_invert_cell, rx_want.invert);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("[text_cursor_window_controller_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_cmd(logic [3:0] op, int code, int col, int row);
        t_cursor_cmd c;
        c.op   = op;
        c.code = CODE_W'(code);
        c.col  = COL_BITS'(col);
        c.row  = ROW_BITS'(row);
        command_queue.push_back(c);
        cmds_queued++;
    endtask

    // setup + access phase; register lands on the edge with penable high
    task automatic apb_write(t_reg idx, int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIN_LEFT:   wnd_left   = value & ((1 << COL_BITS) - 1);
            REG_WIN_RIGHT:  wnd_right  = value & ((1 << COL_BITS) - 1);
            REG_WIN_TOP:    wnd_top    = value & ((1 << ROW_BITS) - 1);
            REG_WIN_BOTTOM: wnd_bottom = value & ((1 << ROW_BITS) - 1);
            default: ;
        endcase
    endtask

    task automatic set_window(int l, int r, int t, int b);
        apb_write(REG_WIN_LEFT, l);
        apb_write(REG_WIN_RIGHT, r);
        apb_write(REG_WIN_TOP, t);
        apb_write(REG_WIN_BOTTOM, b);
    endtask

    // block until every queued command has transferred and its result came back
    task automatic wait_idle();
        do @(posedge i_clk);
        while (cmds_accepted != cmds_queued || expected_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // weighted command mix; writes and moves dominate, set mostly lands inside
    task automatic queue_random(int count);
        int pick;
        int code;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            code = $urandom_range(0, 255);
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 5))
                    0: code = CHAR_SPACE - 1;
                    1: code = CHAR_SPACE;
                    2: code = CHAR_DEL - 1;
                    3: code = CHAR_DEL;
                    4: code = CHAR_DEL + 1;
                    default: code = 0;
                endcase
            end
            if (pick < 30) begin
                queue_cmd(OP_WRITE, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else if (pick < 40) begin
                queue_cmd(OP_RIGHT, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else if (pick < 48) begin
                queue_cmd(OP_LEFT, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else if (pick < 56) begin
                queue_cmd(OP_DOWN, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else if (pick < 64) begin
                queue_cmd(OP_UP, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else if (pick < 71) begin
                queue_cmd(OP_SET, code, $urandom_range(0, col_span()),
                          $urandom_range(0, row_span()));
            end else if (pick < 74) begin
                queue_cmd(OP_SET, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else if (pick < 77) begin
                queue_cmd(OP_HOME, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else if (pick < 80) begin
                queue_cmd(OP_RETURN, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else if (pick < 84) begin
                queue_cmd(OP_SHOW, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else if (pick < 88) begin
                queue_cmd(OP_HIDE, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else if (pick < 91) begin
                queue_cmd(OP_ENABLE, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else if (pick < 94) begin
                queue_cmd(OP_DISABLE, code, $urandom_range(0, 127), $urandom_range(0, 63));
            end else begin
                queue_cmd(4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), code,
                          $urandom_range(0, 127), $urandom_range(0, 63));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset window 0..79 x 0..59, no idling
        queue_cmd(OP_SHOW, 0, 0, 0);                // hidden -> invert
        queue_cmd(OP_SHOW, 0, 0, 0);                // already shown
        queue_cmd(OP_HIDE, 0, 0, 0);                // invert back
        queue_cmd(OP_HIDE, 0, 0, 0);                // already hidden
        queue_cmd(OP_DISABLE, 0, 0, 0);             // hidden, nothing to undo
        queue_cmd(OP_SHOW, 0, 0, 0);                // disabled, no invert
        queue_cmd(OP_ENABLE, 0, 0, 0);
        queue_cmd(OP_SHOW, 0, 0, 0);
        queue_cmd(OP_DISABLE, 0, 0, 0);             // shown -> hide then disable
        queue_cmd(OP_ENABLE, 0, 0, 0);
        queue_cmd(OP_UP, 0, 0, 0);                  // top row -> scroll down
        queue_cmd(OP_LEFT, 0, 0, 0);                // wrap to last col, top row
        queue_cmd(OP_SET, 0, 79, 59);               // bottom-right corner
        queue_cmd(OP_RIGHT, 0, 0, 0);               // wrap on last row -> scroll up
        queue_cmd(OP_SET, 0, 80, 10);               // past last col, dropped
        queue_cmd(OP_SET, 0, 127, 63);              // all ones, dropped
        queue_cmd(OP_DOWN, 0, 0, 0);                // last row -> scroll up
        queue_cmd(OP_RETURN, 0, 0, 0);
        queue_cmd(OP_HOME, 0, 0, 0);
        queue_cmd(OP_WRITE, 65, 0, 0);
        queue_cmd(OP_WRITE, CHAR_SPACE - 1, 0, 0);  // control code: move only
        queue_cmd(OP_WRITE, CHAR_DEL, 0, 0);        // DEL: move only
        queue_cmd(OP_WRITE, CHAR_SPACE, 0, 0);
        queue_cmd(OP_WRITE, 255, 0, 0);
        queue_cmd(OP_SPARE_HI, 255, 127, 63);       // undefined opcode, no effect
        wait_idle();

        // full-size window, draw on the far corner
        set_window(0, 127, 0, 63);
        queue_cmd(OP_SET, 0, 127, 63);
        queue_cmd(OP_WRITE, CHAR_DEL + 1, 0, 0);
        gaps_on = 1'b1;
        queue_random(190);
        wait_idle();

        // single-cell window at the top corner of the address space
        set_window(127, 127, 63, 63);
        queue_random(150);
        wait_idle();

        // both axes inverted: collapses to one cell, writes never draw
        set_window(100, 20, 50, 10);
        queue_random(150);
        wait_idle();

        // back-pressure: receiver holds off while the sender streams
        gaps_on = 1'b0;
        set_window(10, 40, 5, 20);
        hold_seq++;
        queue_random(190);
        wait_idle();

        // reset geometry again, with idling
        gaps_on = 1'b1;
        set_window(0, WIN_RIGHT_RST, 0, WIN_BOTTOM_RST);
        queue_random(190);
        wait_idle();

        // park the cursor far out, then shrink the window under it
        set_window(0, 127, 0, 63);
        queue_cmd(OP_SET, 0, 120, 60);
        wait_idle();
        set_window(3, 12, 2, 6);
        queue_random(150);
        wait_idle();

        // arbitrary windows, some inverted
        for (int p = 0; p < 3; p++) begin
            set_window($urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 63), $urandom_range(0, 63));
            queue_random(170);
            wait_idle();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[text_cursor_window_controller_top] OK");
        end else begin
            $display("[text_cursor_window_controller_top] ERROR");
        end
        $finish;
    end

endmodule
